@@ design/dsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, character codes, frame offsets and helper functions for the
// depth sentence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsp_pkg;

	// frame geometry
	localparam int FRAME_LENGTH = 38;
	localparam int OFFSET_W     = 6;
	localparam int DEPTH_W      = 17;
	localparam int FIELD_COUNT  = 3;
	localparam int FIELD_BASE   = 7;
	localparam int FIELD_STRIDE = 9;
	localparam int OFF_CHK_HI   = 34;
	localparam int OFF_CHK_LO   = 35;

	// character codes
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPR_A  = 8'h41;
	localparam logic [7:0] CHAR_UPR_F  = 8'h46;

	// field index code for an offset that carries no depth digit
	localparam logic [1:0] FIELD_NONE = 2'd3;

	typedef logic [DEPTH_W-1:0] depth_t;
	typedef depth_t [FIELD_COUNT-1:0] depth_arr_t;

	// per-byte control from the frame controller to the depth store
	typedef struct packed {
		logic       start;     // '$' seen: clear accumulators
		logic       digit_en;  // valid digit at a depth digit offset
		logic [1:0] field_idx; // which depth field
		logic [3:0] digit;     // digit value
		logic       fire;      // checksum low digit: result goes out
		logic       ok;        // frame good, take new depths
	} ctrl_t;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// bit 4 set: not an upper-case hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (is_digit(c)) begin
			t = c - CHAR_ZERO;
			hex_value = {1'b0, t[3:0]};
		end else if ((c >= CHAR_UPR_A) && (c <= CHAR_UPR_F)) begin
			t = c - CHAR_UPR_A + 8'd10;
			hex_value = {1'b0, t[3:0]};
		end else begin
			hex_value = 5'b10000;
		end
	endfunction

	// digits sit at base+0,1,2 and base+4,5; base+3 is the decimal point
	function automatic logic [1:0] digit_field(input logic [OFFSET_W-1:0] off);
		int b;
		digit_field = FIELD_NONE;
		for (int k = FIELD_COUNT - 1; k >= 0; k--) begin
			b = FIELD_BASE + FIELD_STRIDE * k;
			if ((int'(off) == b) || (int'(off) == b + 1) || (int'(off) == b + 2) ||
			    (int'(off) == b + 4) || (int'(off) == b + 5)) begin
				digit_field = 2'(k);
			end
		end
	endfunction

endpackage

`default_nettype wire

@@ design/dsp_frame_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsp_frame_ctrl
// Frame tracking: offset counter, checksum XOR, star flag, format check and
// the sent checksum high nibble. Issues per-byte control to the depth store.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_frame_ctrl #(
	parameter int FRAME_LENGTH = dsp_pkg::FRAME_LENGTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    rx_byte,
	output dsp_pkg::ctrl_t     ctrl,
	output logic [7:0]         xor_next
);

	logic                           in_frame_q, in_frame_n;
	logic [dsp_pkg::OFFSET_W-1:0]   offset_q, offset_n;
	logic                           before_star_q, before_star_n;
	logic [7:0]                     xor_q, xor_n;
	logic [3:0]                     chk_hi_q, chk_hi_n;
	logic                           bad_q, bad_n;

	logic [dsp_pkg::OFFSET_W:0]     off_inc;
	logic [1:0]                     fidx;
	logic [4:0]                     hx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			offset_q      <= '0;
			before_star_q <= 1'b0;
			xor_q         <= '0;
			chk_hi_q      <= '0;
			bad_q         <= 1'b0;
		end else begin
			in_frame_q    <= in_frame_n;
			offset_q      <= offset_n;
			before_star_q <= before_star_n;
			xor_q         <= xor_n;
			chk_hi_q      <= chk_hi_n;
			bad_q         <= bad_n;
		end
	end

	always_comb begin
		in_frame_n    = in_frame_q;
		offset_n      = offset_q;
		before_star_n = before_star_q;
		xor_n         = xor_q;
		chk_hi_n      = chk_hi_q;
		bad_n         = bad_q;
		ctrl          = '0;
		ctrl.field_idx = dsp_pkg::FIELD_NONE;
		off_inc       = {1'b0, offset_q} + 1'b1;
		fidx          = dsp_pkg::digit_field(off_inc[dsp_pkg::OFFSET_W-1:0]);
		hx            = dsp_pkg::hex_value(rx_byte);

		if (step) begin
			if (rx_byte == dsp_pkg::CHAR_DOLLAR) begin
				in_frame_n    = 1'b1;
				offset_n      = '0;
				before_star_n = 1'b1;
				xor_n         = '0;
				chk_hi_n      = '0;
				bad_n         = 1'b0;
				ctrl.start    = 1'b1;
			end else if (in_frame_q) begin
				if (off_inc >= (dsp_pkg::OFFSET_W+1)'(FRAME_LENGTH)) begin
					// overlong frame: dropped silently
					in_frame_n = 1'b0;
				end else begin
					offset_n = off_inc[dsp_pkg::OFFSET_W-1:0];
					if (before_star_q) begin
						if (rx_byte == dsp_pkg::CHAR_STAR) begin
							before_star_n = 1'b0;
						end else begin
							xor_n = xor_q ^ rx_byte;
						end
					end
					if (fidx != dsp_pkg::FIELD_NONE) begin
						if (dsp_pkg::is_digit(rx_byte)) begin
							ctrl.digit_en  = 1'b1;
							ctrl.field_idx = fidx;
							ctrl.digit     = rx_byte[3:0];
						end else begin
							bad_n = 1'b1;
						end
					end else if (off_inc ==
					             (dsp_pkg::OFFSET_W+1)'(dsp_pkg::OFF_CHK_HI)) begin
						if (hx[4]) begin
							bad_n    = 1'b1;
							chk_hi_n = '0;
						end else begin
							chk_hi_n = hx[3:0];
						end
					end else if (off_inc ==
					             (dsp_pkg::OFFSET_W+1)'(dsp_pkg::OFF_CHK_LO)) begin
						bad_n      = bad_q | hx[4];
						ctrl.fire  = 1'b1;
						ctrl.ok    = !bad_q && !hx[4] && !before_star_n &&
						             ({chk_hi_q, hx[3:0]} == xor_n);
						in_frame_n = 1'b0;
					end
				end
			end
		end
		xor_next = xor_n;
	end

endmodule

`default_nettype wire

@@ design/dsp_depth_store.sv @@
// ----------------------------------------------------------------------------
// dsp_depth_store
// Three decimal field accumulators (hundredths) and the held depths, which
// take the gathered fields only on a good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_depth_store (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dsp_pkg::ctrl_t   ctrl,
	output dsp_pkg::depth_arr_t   depth_next
);

	dsp_pkg::depth_arr_t acc_q;
	dsp_pkg::depth_arr_t held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else begin
			for (int k = 0; k < dsp_pkg::FIELD_COUNT; k++) begin
				if (ctrl.start) begin
					acc_q[k] <= '0;
				end else if (ctrl.digit_en && (ctrl.field_idx == 2'(k))) begin
					// acc*10 + d, kept to field width
					acc_q[k] <= (acc_q[k] << 3) + (acc_q[k] << 1) +
					            dsp_pkg::DEPTH_W'(ctrl.digit);
				end
			end
			if (ctrl.fire && ctrl.ok) begin
				held_q <= acc_q;
			end
		end
	end

	assign depth_next = (ctrl.fire && ctrl.ok) ? acc_q : held_q;

endmodule

`default_nettype wire

@@ design/depth_sentence_parser.sv @@
// ----------------------------------------------------------------------------
// depth_sentence_parser
// Byte-stream parser for depth below transducer sentences: checksum, three
// fixed-position ddd.dd depth fields, and held depths updated on good frames.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  input   | in_valid  / in_stall   | rx_byte
//  output  | out_valid / out_stall  | depth_feet, depth_metres, depth_fathoms,
//          |                        | frame_ok, computed_xor
//
//  One byte per cycle sustained while out_stall is low. A byte transfer lands
//  in the input register; when the result register can take a value, the frame
//  logic updates state from it and, on the checksum low digit, loads the result
//  register. Input register and result register decouple the sides: a new byte
//  is taken while a result waits, and in_stall rises only when both registers
//  are full and out_stall is high.
//  arst_n clears frame state, accumulators and held depths to zero.
//
`default_nettype none

module depth_sentence_parser #(
	parameter int FRAME_LENGTH = dsp_pkg::FRAME_LENGTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [16:0]       depth_feet,
	output logic [16:0]       depth_metres,
	output logic [16:0]       depth_fathoms,
	output logic              frame_ok,
	output logic [7:0]        computed_xor
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// result register
	logic        out_valid_q;
	dsp_pkg::depth_t feet_q, metres_q, fathoms_q;
	logic        ok_q;
	logic [7:0]  xor_q;

	logic                advance;
	logic                step;
	dsp_pkg::ctrl_t      ctrl;
	logic [7:0]          xor_next;
	dsp_pkg::depth_arr_t depth_next;

	// stage 1 moves on whenever the result register can take a new value
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	dsp_frame_ctrl #(
		.FRAME_LENGTH (FRAME_LENGTH)
	) u_frame_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.ctrl     (ctrl),
		.xor_next (xor_next)
	);

	dsp_depth_store u_depth_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.depth_next (depth_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ctrl.fire;
		end
	end

	// result payload, loaded only with a new result
	always_ff @(posedge clk) begin
		if (advance && ctrl.fire) begin
			feet_q    <= depth_next[0];
			metres_q  <= depth_next[1];
			fathoms_q <= depth_next[2];
			ok_q      <= ctrl.ok;
			xor_q     <= xor_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign depth_feet    = feet_q;
	assign depth_metres  = metres_q;
	assign depth_fathoms = fathoms_q;
	assign frame_ok      = ok_q;
	assign computed_xor  = xor_q;

	// a result is only raised by a byte the frame logic actually took
	a_fire_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire |-> step)
		else $error("result raised without a processed byte");

	// the checksum digit byte is never also a depth digit
	a_fire_not_digit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fire |-> !ctrl.digit_en && !ctrl.start)
		else $error("result byte also updates a depth field");

	// a fired result lands in the result register
	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ctrl.fire) |=> out_valid_q)
		else $error("fired result lost");

	// a good frame always raises a result flagged good
	a_ok_depths: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ctrl.fire && ctrl.ok) |=> (frame_ok && out_valid_q))
		else $error("good frame not flagged");

endmodule

`default_nettype wire

@@ dv/depth_sentence_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_sentence_parser_tb
// Self-checking bench for the depth sentence parser. Byte streams built from
// DBT-style sentences (clean, corrupted, restarted and interleaved with line
// noise) go in; a byte-level predictor works out each result, and every
// result transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module depth_sentence_parser_tb;
	import dsp_pkg::*;

	localparam int          SENTENCE_LEN  = OFF_CHK_LO + 1;  // '$' up to last checksum digit
	localparam int          ITEM_TARGET   = 1350;           // at least this many bytes queued in all
	localparam int          MIN_SENTENCES = 16;             // complete random sentences
	localparam int          TAIL_BYTES    = 200;            // last stretch runs flat out
	localparam int          RESET_CYCLES  = 7;
	localparam int          DRAIN_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int          DEPTH_MAX     = 99999;
	localparam logic [7:0]  CHAR_CR       = 8'h0D;
	localparam logic [7:0]  CHAR_LF       = 8'h0A;
	localparam logic [7:0]  CHAR_LWR_A    = "a";
	localparam logic [7:0]  CHAR_UPR_G    = "G";
	localparam logic [7:0]  CHAR_COLON    = ":";
	localparam logic [7:0]  CHAR_SLASH    = "/";
	localparam logic [7:0]  CHAR_COMMA    = ",";
	localparam logic [7:0]  CHAR_X        = "X";
	// all three depth fields start at zero; the checksum slot is filled in later
	localparam string       DBT_TEMPLATE  = "$SDDBT,000.00,f,000.00,M,000.00,F*00";

	// one result transfer as the parser should present it
	typedef struct {
		depth_t     feet;
		depth_t     metres;
		depth_t     fathoms;
		logic       ok;
		logic [7:0] xsum;
	} depth_reading_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_stall;
	logic [7:0]    rx_byte   = 8'h00;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [16:0]   depth_feet;
	logic [16:0]   depth_metres;
	logic [16:0]   depth_fathoms;
	logic          frame_ok;
	logic [7:0]    computed_xor;

	// stimulus side
	logic [7:0]     byte_q [$];                // bytes waiting to be sent
	logic [7:0]     sentence [0:SENTENCE_LEN-1];
	int             sentences_made = 0;
	int             gap_left       = 0;
	int             hold_left      = 0;
	logic           calm           = 1'b0;     // no idling once the queue runs low
	int unsigned    cycle_count    = 0;

	// predictor state, a shadow of the parser
	logic           in_sentence = 1'b0;
	int             sentence_pos = 0;
	logic           xor_open = 1'b0;           // still before the star
	logic [7:0]     run_xor = 8'h00;
	depth_t         field_sum [FIELD_COUNT];
	logic [3:0]     hi_nib = 4'h0;
	logic           malformed = 1'b0;
	depth_t         held [FIELD_COUNT];
	depth_reading_t readings_due [$];

	// score keeping
	int             errors = 0;
	int             bytes_taken = 0;
	int             readings_seen = 0;
	int             good_seen = 0;

	depth_sentence_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.depth_feet   (depth_feet),
		.depth_metres (depth_metres),
		.depth_fathoms(depth_fathoms),
		.frame_ok     (frame_ok),
		.computed_xor (computed_xor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// depth field that owns a digit at this offset, -1 where there is none
	// (the decimal point sits at base+3 and is never checked)
	function automatic int digit_slot(input int off);
		int b;
		digit_slot = -1;
		for (int k = 0; k < FIELD_COUNT; k++) begin
			b = FIELD_BASE + FIELD_STRIDE * k;
			if (off >= b && off <= b + 5 && off != b + 3)
				digit_slot = k;
		end
	endfunction

	// upper-case hex only; anything else gives -1
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return int'(c - CHAR_ZERO);
		if (c >= CHAR_UPR_A && c <= CHAR_UPR_F)
			return int'(c - CHAR_UPR_A) + 10;
		return -1;
	endfunction

	// advance the shadow state by one accepted byte; the low checksum digit
	// queues the reading that the parser must produce for it
	task automatic take_byte(input logic [7:0] c);
		int             pos_next;
		int             slot;
		int             nib;
		logic           good;
		depth_reading_t r;
		if (c == CHAR_DOLLAR) begin
			// a dollar always (re)opens a sentence, even mid-sentence
			in_sentence  = 1'b1;
			sentence_pos = 0;
			xor_open     = 1'b1;
			run_xor      = 8'h00;
			hi_nib       = 4'h0;
			malformed    = 1'b0;
			foreach (field_sum[i])
				field_sum[i] = '0;
			return;
		end
		if (!in_sentence)
			return;                             // line noise between sentences
		pos_next = sentence_pos + 1;
		if (pos_next >= FRAME_LENGTH) begin
			in_sentence = 1'b0;                 // overlong: dropped silently
			return;
		end
		sentence_pos = pos_next;
		if (xor_open) begin
			if (c == CHAR_STAR)
				xor_open = 1'b0;
			else
				run_xor = run_xor ^ c;
		end
		slot = digit_slot(pos_next);
		if (slot >= 0) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				field_sum[slot] = depth_t'(int'(field_sum[slot]) * 10 + int'(c - CHAR_ZERO));
			else
				malformed = 1'b1;
		end else if (pos_next == OFF_CHK_HI) begin
			nib = nibble_of(c);
			if (nib < 0) begin
				malformed = 1'b1;
				nib = 0;
			end
			hi_nib = 4'(nib);
		end else if (pos_next == OFF_CHK_LO) begin
			nib = nibble_of(c);
			if (nib < 0) begin
				malformed = 1'b1;
				nib = 0;
			end
			// a missing star leaves xor_open set and fails the sentence
			good = !malformed && !xor_open && ({hi_nib, 4'(nib)} == run_xor);
			if (good)
				held = field_sum;
			r.feet    = held[0];
			r.metres  = held[1];
			r.fathoms = held[2];
			r.ok      = good;
			r.xsum    = run_xor;
			readings_due.push_back(r);
			in_sentence = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sentence construction
	// ------------------------------------------------------------------------

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_UPR_A + 8'(n) - 8'd10;
	endfunction

	// checksum as a talker would send it: bytes after '$' up to the star
	function automatic logic [7:0] sentence_xor();
		logic [7:0] x;
		x = 8'h00;
		for (int i = 1; i < OFF_CHK_HI; i++) begin
			if (sentence[i] == CHAR_STAR)
				break;
			x = x ^ sentence[i];
		end
		return x;
	endfunction

	task automatic put_checksum(input logic [7:0] v);
		sentence[OFF_CHK_HI] = hex_char(v[7:4]);
		sentence[OFF_CHK_LO] = hex_char(v[3:0]);
	endtask

	task automatic seal();
		put_checksum(sentence_xor());
	endtask

	// clean sentence with the three depths in hundredths, ddd.dd each
	task automatic compose(input int unsigned ft, input int unsigned mt, input int unsigned fm);
		int unsigned vals [FIELD_COUNT];
		int unsigned v;
		int          b;
		vals[0] = ft;
		vals[1] = mt;
		vals[2] = fm;
		for (int i = 0; i < SENTENCE_LEN; i++)
			sentence[i] = DBT_TEMPLATE[i];
		for (int k = 0; k < FIELD_COUNT; k++) begin
			b = FIELD_BASE + FIELD_STRIDE * k;
			v = vals[k];
			// least significant digit last, so fill from the right
			sentence[b + 5] = CHAR_ZERO + 8'(v % 10); v = v / 10;
			sentence[b + 4] = CHAR_ZERO + 8'(v % 10); v = v / 10;
			sentence[b + 2] = CHAR_ZERO + 8'(v % 10); v = v / 10;
			sentence[b + 1] = CHAR_ZERO + 8'(v % 10); v = v / 10;
			sentence[b]     = CHAR_ZERO + 8'(v % 10);
		end
		seal();
	endtask

	function automatic int unsigned pick_depth();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return DEPTH_MAX;
			default: return $urandom_range(0, DEPTH_MAX);
		endcase
	endfunction

	// any byte but a dollar, so a corrupted sentence still runs to its end
	function automatic logic [7:0] stray_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHAR_DOLLAR);
		return c;
	endfunction

	task automatic queue_sentence(input int n);
		for (int i = 0; i < n; i++)
			byte_q.push_back(sentence[i]);
		if (n == SENTENCE_LEN)
			sentences_made++;
	endtask

	// what follows a sentence on the wire: usually CR LF, sometimes junk,
	// now and then including a dollar that opens a stub sentence
	task automatic queue_trailer();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 5))
				byte_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			byte_q.push_back(CHAR_CR);
			byte_q.push_back(CHAR_LF);
		end
	endtask

	task automatic random_sentence();
		int unsigned mode;
		int          r;
		logic [7:0]  c;
		compose(pick_depth(), pick_depth(), pick_depth());
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			put_checksum(sentence_xor() ^ 8'($urandom_range(1, 255)));
		end else if (mode < 15) begin
			// wrong character at a depth digit
			r = $urandom_range(0, 4);
			if (r >= 3)
				r++;
			sentence[FIELD_BASE + FIELD_STRIDE * $urandom_range(0, FIELD_COUNT - 1) + r] =
				stray_byte();
			seal();
		end else if (mode < 21) begin
			sentence[OFF_CHK_HI + $urandom_range(0, 1)] = stray_byte();
		end else if (mode < 26) begin
			// star lost: checksum covers everything through the digits
			do
				c = stray_byte();
			while (c == CHAR_STAR);
			sentence[OFF_CHK_HI - 1] = c;
			put_checksum(sentence_xor());
		end else if (mode < 31) begin
			sentence[$urandom_range(1, OFF_CHK_HI - 2)] = CHAR_STAR;
			seal();
		end else if (mode < 35) begin
			// cut short by a fresh dollar
			queue_sentence($urandom_range(1, SENTENCE_LEN - 1));
			compose(pick_depth(), pick_depth(), pick_depth());
		end else if (mode < 40) begin
			repeat ($urandom_range(1, 4))
				sentence[$urandom_range(1, SENTENCE_LEN - 1)] = stray_byte();
			if ($urandom_range(0, 1) != 0)
				seal();
		end
		// the rest stay well formed
		queue_sentence(SENTENCE_LEN);
		queue_trailer();
	endtask

	// ------------------------------------------------------------------------
	// Stimulus plan and end of run
	// ------------------------------------------------------------------------
	initial begin
		foreach (field_sum[i]) begin
			field_sum[i] = '0;
			held[i]      = '0;
		end

		// directed: extremes, then each failure kind, with held depths
		// expected to survive every rejected sentence
		compose(0, 0, 0);                          queue_sentence(SENTENCE_LEN);
		compose(DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);  queue_sentence(SENTENCE_LEN);
		compose(12345, 3762, 2057);                queue_sentence(SENTENCE_LEN);
		queue_trailer();
		compose(500, 152, 83);                     // checksum off by one bit
		put_checksum(sentence_xor() ^ 8'h01);      queue_sentence(SENTENCE_LEN);
		compose(777, 236, 129);                    // colon just above '9' in feet
		sentence[FIELD_BASE + 1] = CHAR_COLON;
		seal();                                    queue_sentence(SENTENCE_LEN);
		compose(777, 236, 129);                    // slash just below '0' in fathoms
		sentence[FIELD_BASE + 2 * FIELD_STRIDE + 5] = CHAR_SLASH;
		seal();                                    queue_sentence(SENTENCE_LEN);
		compose(4242, 1293, 707);                  // lower-case checksum digit
		sentence[OFF_CHK_LO] = CHAR_LWR_A;         queue_sentence(SENTENCE_LEN);
		compose(4242, 1293, 707);                  // 'G' just past hex range
		sentence[OFF_CHK_HI] = CHAR_UPR_G;         queue_sentence(SENTENCE_LEN);
		compose(8888, 2709, 1481);                 // no star at all
		sentence[OFF_CHK_HI - 1] = CHAR_COMMA;
		put_checksum(sentence_xor());              queue_sentence(SENTENCE_LEN);
		compose(31, 9, 5);                         // dollar restarts mid-sentence
		queue_sentence(20);
		compose(31, 9, 5);                         queue_sentence(SENTENCE_LEN);
		// noise outside a sentence is ignored
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		byte_q.push_back(CHAR_STAR);
		byte_q.push_back(CHAR_ZERO);
		compose(60000, 18288, 10000);              // early star: short checksum, good
		sentence[FIELD_BASE - 1] = CHAR_STAR;
		seal();                                    queue_sentence(SENTENCE_LEN);
		compose(1, 2, 3);                          // junk at a decimal point passes
		sentence[FIELD_BASE + 3] = CHAR_X;
		seal();                                    queue_sentence(SENTENCE_LEN);
		queue_trailer();

		// random part, topping the queue up to the byte budget
		sentences_made = 0;
		while (byte_q.size() < ITEM_TARGET || sentences_made < MIN_SENTENCES)
			random_sentence();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// all bytes across, then all readings back, then a short drain
		while (byte_q.size() != 0 || in_valid)
			@(posedge clk);
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d bytes; %0d readings checked, %0d good and %0d rejected.",
			bytes_taken, readings_seen, good_seen, readings_seen - good_seen);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Byte driver: takes the next byte once the current one has been
	// accepted; idle bursts only start between transfers, never while a
	// byte is on offer. Bit 10 of the cycle count gives idle-free stretches.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'h00;
			calm     <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				take_byte(rx_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!calm && !cycle_count[10] && $urandom_range(0, 11) == 0) begin
					gap_left = $urandom_range(1, 19) - 1;
					in_valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					rx_byte  <= byte_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			calm <= (byte_q.size() < TAIL_BYTES);
		end
	end

	// ------------------------------------------------------------------------
	// Result side back-pressure: random stall bursts, quiet while bit 9 of
	// the cycle count is set and through the final stretch.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!calm && !cycle_count[9] && $urandom_range(0, 15) == 0) begin
			hold_left = $urandom_range(1, 19) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------
	function automatic int field_differs(input string name, input int want, input int got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	depth_reading_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			readings_seen++;
			if (frame_ok)
				good_seen++;
			if (readings_due.size() == 0) begin
				$error("reading transfer with nothing outstanding");
				errors++;
			end else begin
				want = readings_due.pop_front();
				errors += field_differs("depth_feet",    want.feet,    depth_feet);
				errors += field_differs("depth_metres",  want.metres,  depth_metres);
				errors += field_differs("depth_fathoms", want.fathoms, depth_fathoms);
				errors += field_differs("frame_ok",      want.ok,      frame_ok);
				errors += field_differs("computed_xor",  want.xsum,    computed_xor);
			end
		end
	end

	// cycle count for idle phasing and the overall time limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

@@ sim.f @@
design/dsp_pkg.sv
design/dsp_frame_ctrl.sv
design/dsp_depth_store.sv
design/depth_sentence_parser.sv
dv/depth_sentence_parser_tb.sv
